@@ rtl/bmrf_pkg.sv @@
// Shared constants and types for the RGB box mean filter.
package bmrf_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned DIM_W     = 11;
  localparam int unsigned REACH_W   = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned MAX_ROWS  = 1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REACH  = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_NONE   = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_WAIT,
    BK_DIV,
    BK_OUT
  } back_state_e;

endpackage

@@ rtl/bmrf_fifo.sv @@
// Four-entry word queue between the front and back parts.
module bmrf_fifo #(
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic [DW-1:0] rdata_o,
  output logic          empty_o
);
  logic [DW-1:0] mem_q [4];
  logic [1:0]    wptr_q, rptr_q;
  logic [2:0]    cnt_q;

  assign full_o  = (cnt_q == 3'd4);
  assign empty_o = (cnt_q == 3'd0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 2'd1;
      if (pop_i)  rptr_q <= rptr_q + 2'd1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 3'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 3'd1;
    end
  end
endmodule

@@ rtl/bmrf_front.sv @@
// Front part: takes words, tracks raster positions and decides when a mean is due.
module bmrf_front #(
  parameter int unsigned MAX_REACH = 3,
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned RCW = $clog2(MAX_REACH + 1),
  parameter int unsigned CW  = $clog2(MAX_WIDTH),
  parameter int unsigned WW  = $clog2(MAX_WIDTH + 1),
  parameter int unsigned RGW = $clog2(2 * MAX_REACH + 2)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          restart_i,
  input  logic [RCW-1:0]                reach_i,
  input  logic [WW-1:0]                 width_i,
  input  logic [bmrf_pkg::DIM_W-1:0]    height_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output logic                          wr_o,
  output logic [CW-1:0]                 wr_col_o,
  output logic [RGW-1:0]                wr_ring_o,
  output logic                          em_o,
  output logic [CW-1:0]                 em_col_o,
  output logic [bmrf_pkg::POS_W-1:0]    em_row_o,
  output logic [RGW-1:0]                em_ring_o,
  output logic                          em_last_o
);
  import bmrf_pkg::*;

  localparam int unsigned XW   = WW + 1;
  localparam int unsigned YW   = DIM_W + 1;
  localparam int unsigned RING = 2 * MAX_REACH + 2;

  logic [CW-1:0]    in_col_q, in_col_d, em_col_q, em_col_d;
  logic [DIM_W-1:0] in_row_q, in_row_d;
  logic [POS_W-1:0] em_row_q, em_row_d;
  logic [RGW-1:0]   in_ring_q, in_ring_d, em_ring_q, em_ring_d;

  logic             accept, wr, em, last;
  logic [CW-1:0]    col_n;
  logic [DIM_W-1:0] row_n;
  logic [RGW-1:0]   ring_n;
  logic [XW-1:0]    ex, xlim, nx, wm1;
  logic [YW-1:0]    ey, ylim, ny, hm1, rown;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;

  always_comb begin
    wr     = !mode_i && ({1'b0, in_row_q} < {1'b0, height_i});
    col_n  = in_col_q;
    row_n  = in_row_q;
    ring_n = in_ring_q;
    if (wr) begin
      if (XW'(in_col_q) + XW'(1) >= XW'(width_i)) begin
        col_n  = '0;
        row_n  = in_row_q + DIM_W'(1);
        ring_n = (in_ring_q == RGW'(RING - 1)) ? '0 : in_ring_q + RGW'(1);
      end else begin
        col_n = in_col_q + CW'(1);
      end
    end

    ex   = XW'(em_col_q);
    ey   = YW'(em_row_q);
    wm1  = XW'(width_i) - XW'(1);
    hm1  = YW'(height_i) - YW'(1);
    xlim = ex + XW'(reach_i);
    ylim = ey + YW'(reach_i);
    nx   = (xlim > wm1) ? wm1 : xlim;
    ny   = (ylim > hm1) ? hm1 : ylim;
    rown = YW'(row_n);
    em   = (ex <= wm1) && (ey <= hm1) &&
           ((ny < rown) || ((ny == rown) && (nx < XW'(col_n))));
    last = (ex == wm1) && (ey == hm1);

    in_col_d  = col_n;
    in_row_d  = row_n;
    in_ring_d = ring_n;
    em_col_d  = em_col_q;
    em_row_d  = em_row_q;
    em_ring_d = em_ring_q;
    if (em) begin
      if (ex + XW'(1) >= XW'(width_i)) begin
        em_col_d  = '0;
        em_row_d  = em_row_q + POS_W'(1);
        em_ring_d = (em_ring_q == RGW'(RING - 1)) ? '0 : em_ring_q + RGW'(1);
      end else begin
        em_col_d = em_col_q + CW'(1);
      end
    end
    // frame done: every counter back to the origin
    if (em && last) begin
      in_col_d  = '0;
      in_row_d  = '0;
      in_ring_d = '0;
      em_col_d  = '0;
      em_row_d  = '0;
      em_ring_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      in_ring_q <= '0;
      em_col_q  <= '0;
      em_row_q  <= '0;
      em_ring_q <= '0;
    end else if (restart_i) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      in_ring_q <= '0;
      em_col_q  <= '0;
      em_row_q  <= '0;
      em_ring_q <= '0;
    end else if (accept) begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      in_ring_q <= in_ring_d;
      em_col_q  <= em_col_d;
      em_row_q  <= em_row_d;
      em_ring_q <= em_ring_d;
    end
  end

  assign q_push_o  = accept && (wr || em);
  assign wr_o      = wr;
  assign wr_col_o  = in_col_q;
  assign wr_ring_o = in_ring_q;
  assign em_o      = em;
  assign em_col_o  = em_col_q;
  assign em_row_o  = em_row_q;
  assign em_ring_o = em_ring_q;
  assign em_last_o = last;
endmodule

@@ rtl/bmrf_back.sv @@
// Back part: line store, window accumulation, serial divide and output register.
module bmrf_back #(
  parameter int unsigned MAX_REACH = 3,
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned RCW = $clog2(MAX_REACH + 1),
  parameter int unsigned CW  = $clog2(MAX_WIDTH),
  parameter int unsigned WW  = $clog2(MAX_WIDTH + 1),
  parameter int unsigned RGW = $clog2(2 * MAX_REACH + 2)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [RCW-1:0]                reach_i,
  input  logic [WW-1:0]                 width_i,
  input  logic [bmrf_pkg::DIM_W-1:0]    height_i,
  input  logic                          q_empty_i,
  output logic                          q_pop_o,
  input  logic                          wr_i,
  input  logic [CW-1:0]                 wr_col_i,
  input  logic [RGW-1:0]                wr_ring_i,
  input  logic [3*bmrf_pkg::PIX_W-1:0]  pix_i,
  input  logic                          em_i,
  input  logic [CW-1:0]                 em_col_i,
  input  logic [bmrf_pkg::POS_W-1:0]    em_row_i,
  input  logic [RGW-1:0]                em_ring_i,
  input  logic                          em_last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bmrf_pkg::PIX_W-1:0]    red_o,
  output logic [bmrf_pkg::PIX_W-1:0]    green_o,
  output logic [bmrf_pkg::PIX_W-1:0]    blue_o,
  output logic [bmrf_pkg::POS_W-1:0]    col_o,
  output logic [bmrf_pkg::POS_W-1:0]    row_o,
  output logic                          last_o
);
  import bmrf_pkg::*;

  localparam int unsigned RING  = 2 * MAX_REACH + 2;
  localparam int unsigned WIN   = 2 * MAX_REACH + 1;
  localparam int unsigned DEPTH = RING * MAX_WIDTH;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SUMW  = $clog2(WIN * WIN * 255 + 1);
  localparam int unsigned CNTW  = $clog2(WIN * WIN + 1);
  localparam int unsigned DSW   = $clog2(WIN + 1);
  localparam int unsigned DCW   = $clog2(SUMW);
  localparam int unsigned XW    = WW + 1;
  localparam int unsigned YW    = DIM_W + 1;
  localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH);

  logic [3*PIX_W-1:0] mem [DEPTH];
  logic [3*PIX_W-1:0] rdata_q;

  back_state_e state_q, state_d;
  logic [CW-1:0]  xx_q, x0_q, x1_q;
  logic [RGW-1:0] yring_q;
  logic [DSW-1:0] yrem_q;
  logic [CNTW-1:0] cnt_q;
  logic [DCW-1:0] div_q;
  logic           pend_q;
  logic [SUMW-1:0] sum_q [3];
  logic [CNTW:0]   rem_q [3];
  logic [POS_W-1:0] col_q, row_q;
  logic             last_q;

  logic           pop;
  logic [XW-1:0]  ex, x0, x1, xlim, wm1;
  logic [YW-1:0]  ey, y0, y1, ylim, hm1, dy;
  logic [RGW:0]   ring0;
  logic [AW-1:0]  raddr, waddr;
  logic [CNTW:0]  rem_n [3];
  logic           qbit [3];

  assign pop     = (state_q == BK_IDLE) && !q_empty_i;
  assign q_pop_o = pop;

  always_comb begin
    ex   = XW'(em_col_i);
    ey   = YW'(em_row_i);
    wm1  = XW'(width_i) - XW'(1);
    hm1  = YW'(height_i) - YW'(1);
    xlim = ex + XW'(reach_i);
    ylim = ey + YW'(reach_i);
    x0   = (ex > XW'(reach_i)) ? ex - XW'(reach_i) : '0;
    y0   = (ey > YW'(reach_i)) ? ey - YW'(reach_i) : '0;
    x1   = (xlim > wm1) ? wm1 : xlim;
    y1   = (ylim > hm1) ? hm1 : ylim;
    dy   = ey - y0;
    // step back from the centre row around the ring
    if ({1'b0, em_ring_i} >= (RGW + 1)'(dy)) begin
      ring0 = {1'b0, em_ring_i} - (RGW + 1)'(dy);
    end else begin
      ring0 = {1'b0, em_ring_i} + (RGW + 1)'(RING) - (RGW + 1)'(dy);
    end
  end

  assign raddr = AW'(yring_q) * ROW_STRIDE + AW'(xx_q);
  assign waddr = AW'(wr_ring_i) * ROW_STRIDE + AW'(wr_col_i);

  always_ff @(posedge clk_i) begin
    if (pop && wr_i) begin
      mem[waddr] <= pix_i;
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem_n[i] = {rem_q[i][CNTW-1:0], sum_q[i][SUMW-1]};
      qbit[i]  = (rem_n[i] >= (CNTW + 1)'(cnt_q));
      if (qbit[i]) rem_n[i] = rem_n[i] - (CNTW + 1)'(cnt_q);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (pop && em_i) state_d = BK_SCAN;
      BK_SCAN: if (xx_q == x1_q && yrem_q == '0) state_d = BK_WAIT;
      BK_WAIT: state_d = BK_DIV;
      BK_DIV:  if (div_q == '0) state_d = BK_OUT;
      BK_OUT:  if (!out_stall_i) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= (state_q == BK_SCAN);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && em_i) begin
      x0_q    <= CW'(x0);
      x1_q    <= CW'(x1);
      xx_q    <= CW'(x0);
      yring_q <= RGW'(ring0);
      yrem_q  <= DSW'(y1 - y0);
      cnt_q   <= CNTW'(DSW'(x1 - x0 + XW'(1)) * DSW'(y1 - y0 + YW'(1)));
      col_q   <= POS_W'(em_col_i);
      row_q   <= em_row_i;
      last_q  <= em_last_i;
      for (int i = 0; i < 3; i++) sum_q[i] <= '0;
    end
    if (state_q == BK_SCAN) begin
      if (xx_q == x1_q) begin
        xx_q   <= x0_q;
        yrem_q <= yrem_q - DSW'(1);
        yring_q <= (yring_q == RGW'(RING - 1)) ? '0 : yring_q + RGW'(1);
      end else begin
        xx_q <= xx_q + CW'(1);
      end
    end
    if (pend_q) begin
      sum_q[0] <= sum_q[0] + SUMW'(rdata_q[3*PIX_W-1:2*PIX_W]);
      sum_q[1] <= sum_q[1] + SUMW'(rdata_q[2*PIX_W-1:PIX_W]);
      sum_q[2] <= sum_q[2] + SUMW'(rdata_q[PIX_W-1:0]);
    end
    if (state_q == BK_WAIT) begin
      div_q <= DCW'(SUMW - 1);
      for (int i = 0; i < 3; i++) rem_q[i] <= '0;
    end
    // restoring divide: quotient bits shift into the sum register
    if (state_q == BK_DIV) begin
      div_q <= div_q - DCW'(1);
      for (int i = 0; i < 3; i++) begin
        rem_q[i] <= rem_n[i];
        sum_q[i] <= {sum_q[i][SUMW-2:0], qbit[i]};
      end
    end
  end

  assign out_valid_o = (state_q == BK_OUT);
  assign red_o       = sum_q[0][PIX_W-1:0];
  assign green_o     = sum_q[1][PIX_W-1:0];
  assign blue_o      = sum_q[2][PIX_W-1:0];
  assign col_o       = col_q;
  assign row_o       = row_q;
  assign last_o      = last_q;
endmodule

@@ rtl/box_mean_rgb_filter.sv @@
// Box mean RGB filter top level: configuration registers, front, queue and back.
// Pixels arrive in raster order; the front takes one pixel word per cycle unless the
// queue is full, and the back part then spends, per result, one cycle per window
// position read from the line store ((2r+1)^2 at most), a wait state to finish the sum,
// a bit-serial restoring divide and an output state that holds while the output is
// stalled. The four-word queue lets the front keep taking words while the back is busy.
// Writes to the reach, width or height register restart the frame.
module box_mean_rgb_filter #(
  parameter int unsigned MAX_REACH = 3,
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              mode_i,
  input  logic [bmrf_pkg::PIX_W-1:0]        red_in_i,
  input  logic [bmrf_pkg::PIX_W-1:0]        green_in_i,
  input  logic [bmrf_pkg::PIX_W-1:0]        blue_in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [bmrf_pkg::PIX_W-1:0]        red_mean_o,
  output logic [bmrf_pkg::PIX_W-1:0]        green_mean_o,
  output logic [bmrf_pkg::PIX_W-1:0]        blue_mean_o,
  output logic [bmrf_pkg::POS_W-1:0]        out_column_o,
  output logic [bmrf_pkg::POS_W-1:0]        out_row_o,
  output logic                              frame_end_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bmrf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bmrf_pkg::DIM_W-1:0]        cfg_data_i
);
  import bmrf_pkg::*;

  localparam int unsigned RCW = $clog2(MAX_REACH + 1);
  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RGW = $clog2(2 * MAX_REACH + 2);
  localparam int unsigned QW  = 1 + CW + RGW + 3 * PIX_W + 1 + CW + POS_W + RGW + 1;

  logic [REACH_W-1:0] reach_q;
  logic [DIM_W-1:0]   fw_q, fh_q;
  logic               cfg_we, restart;
  logic [RCW-1:0]     reach_eff;
  logic [WW-1:0]      width_eff;
  logic [DIM_W-1:0]   height_eff;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign restart     = cfg_we && (cfg_reg_e'(cfg_index_i) != REG_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reach_q <= REACH_W'(1);
      fw_q    <= DIM_W'(640);
      fh_q    <= DIM_W'(480);
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_REACH:  reach_q <= cfg_data_i[REACH_W-1:0];
        REG_WIDTH:  fw_q    <= cfg_data_i;
        REG_HEIGHT: fh_q    <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  always_comb begin
    if (32'(reach_q) > 32'(MAX_REACH)) reach_eff = RCW'(MAX_REACH);
    else                               reach_eff = RCW'(reach_q);
    if (fw_q == '0)                          width_eff = WW'(1);
    else if (32'(fw_q) > 32'(MAX_WIDTH))     width_eff = WW'(MAX_WIDTH);
    else                                     width_eff = WW'(fw_q);
    if (fh_q == '0)                          height_eff = DIM_W'(1);
    else if (32'(fh_q) > 32'(MAX_ROWS))      height_eff = DIM_W'(MAX_ROWS);
    else                                     height_eff = fh_q;
  end

  logic               q_full, q_empty, q_push, q_pop;
  logic [QW-1:0]      q_wdata, q_rdata;
  logic [3*PIX_W-1:0] pix;
  logic               f_wr, f_em, f_last;
  logic [CW-1:0]      f_wcol, f_ecol;
  logic [RGW-1:0]     f_wring, f_ering;
  logic [POS_W-1:0]   f_erow;
  logic               b_wr, b_em, b_last;
  logic [CW-1:0]      b_wcol, b_ecol;
  logic [RGW-1:0]     b_wring, b_ering;
  logic [POS_W-1:0]   b_erow;
  logic [3*PIX_W-1:0] b_pix;

  assign pix = {red_in_i, green_in_i, blue_in_i};

  bmrf_front #(.MAX_REACH(MAX_REACH), .MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i, .rst_ni,
    .restart_i  (restart),
    .reach_i    (reach_eff),
    .width_i    (width_eff),
    .height_i   (height_eff),
    .in_valid_i,
    .in_stall_o,
    .mode_i,
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .wr_o       (f_wr),
    .wr_col_o   (f_wcol),
    .wr_ring_o  (f_wring),
    .em_o       (f_em),
    .em_col_o   (f_ecol),
    .em_row_o   (f_erow),
    .em_ring_o  (f_ering),
    .em_last_o  (f_last)
  );

  assign q_wdata = {f_wr, f_wcol, f_wring, pix, f_em, f_ecol, f_erow, f_ering, f_last};
  assign {b_wr, b_wcol, b_wring, b_pix, b_em, b_ecol, b_erow, b_ering, b_last} = q_rdata;

  bmrf_fifo #(.DW(QW)) u_fifo (
    .clk_i, .rst_ni,
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  bmrf_back #(.MAX_REACH(MAX_REACH), .MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk_i, .rst_ni,
    .reach_i     (reach_eff),
    .width_i     (width_eff),
    .height_i    (height_eff),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .wr_i        (b_wr),
    .wr_col_i    (b_wcol),
    .wr_ring_i   (b_wring),
    .pix_i       (b_pix),
    .em_i        (b_em),
    .em_col_i    (b_ecol),
    .em_row_i    (b_erow),
    .em_ring_i   (b_ering),
    .em_last_i   (b_last),
    .out_valid_o,
    .out_stall_i,
    .red_o       (red_mean_o),
    .green_o     (green_mean_o),
    .blue_o      (blue_mean_o),
    .col_o       (out_column_o),
    .row_o       (out_row_o),
    .last_o      (frame_end_o)
  );
endmodule

@@ rtl/bmrf_checker.sv @@
// Port-level checks for the box mean filter, bound to the top level.
module bmrf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_stall_i,
  input logic [7:0] red_mean_i,
  input logic [9:0] out_column_i,
  input logic [9:0] out_row_i,
  input logic       cfg_ready_i
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(red_mean_i) &&
    $stable(out_column_i) && $stable(out_row_i))
    else $error("stalled result word changed");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_i)
    else $error("configuration port refused a word");

  a_reset_quiet: assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_i)
    else $error("result shown straight out of reset");
endmodule

bind box_mean_rgb_filter bmrf_checker u_bmrf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .red_mean_i   (red_mean_o),
  .out_column_i (out_column_o),
  .out_row_i    (out_row_o),
  .cfg_ready_i  (cfg_ready_o)
);

@@ tb/sv/box_mean_rgb_filter_test.sv @@
// Self-checking testbench for the RGB box mean filter: directed and random frames against a mean predictor.
`timescale 1ns / 1ps

module box_mean_rgb_filter_test;
  import bmrf_pkg::*;

  localparam int unsigned RING     = 8;
  localparam int unsigned WIDE_MAX = 1024;
  localparam int unsigned SETTLE   = 600;
  localparam int unsigned HOLD_LEN = 300;
  localparam int unsigned DOG_MAX  = 5000;
  localparam int unsigned N_PIX    = 1450;

  typedef enum logic [2:0] {
    CMD_WORD,
    CMD_CFG,
    CMD_SYNC,
    CMD_PHASE,
    CMD_HOLD
  } cmd_e;

  typedef struct {
    cmd_e                  kind;
    logic                  mode;
    logic [PIX_W-1:0]      red;
    logic [PIX_W-1:0]      green;
    logic [PIX_W-1:0]      blue;
    cfg_reg_e              idx;
    logic [DIM_W-1:0]      data;
    int unsigned           send_pct;
    int unsigned           stall_pct;
  } cmd_t;

  typedef struct {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             fend;
  } mean_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 mode = 1'b0;
  logic [PIX_W-1:0]     red_in = '0;
  logic [PIX_W-1:0]     green_in = '0;
  logic [PIX_W-1:0]     blue_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PIX_W-1:0]     red_mean;
  logic [PIX_W-1:0]     green_mean;
  logic [PIX_W-1:0]     blue_mean;
  logic [POS_W-1:0]     out_column;
  logic [POS_W-1:0]     out_row;
  logic                 frame_end;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;

  box_mean_rgb_filter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .mode_i       (mode),
    .red_in_i     (red_in),
    .green_in_i   (green_in),
    .blue_in_i    (blue_in),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .red_mean_o   (red_mean),
    .green_mean_o (green_mean),
    .blue_mean_o  (blue_mean),
    .out_column_o (out_column),
    .out_row_o    (out_row),
    .frame_end_o  (frame_end),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Mean predictor state
  logic [23:0]        pix_ring [RING][WIDE_MAX];
  logic [REACH_W-1:0] p_reach;
  logic [DIM_W-1:0]   p_width, p_height;
  int unsigned        take_x, take_y, give_x, give_y;
  mean_t              pending_means [$];

  cmd_t        word_plan [$];
  bit          fail_seen = 1'b0;
  bit          waiting = 1'b0;
  int unsigned quiet_cnt = 0;
  int unsigned send_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_seq = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_cnt = 0;
  int unsigned dog_cnt = 0;

  function automatic int unsigned dim_eff(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    return (v > WIDE_MAX) ? WIDE_MAX : v;
  endfunction

  function automatic int unsigned min_of(int unsigned a, int unsigned b);
    return (a < b) ? a : b;
  endfunction

  task automatic restart_frame();
    take_x = 0;
    take_y = 0;
    give_x = 0;
    give_y = 0;
  endtask

  task automatic apply_reg(cfg_reg_e idx, logic [DIM_W-1:0] v);
    case (idx)
      REG_REACH:  p_reach = v[REACH_W-1:0];
      REG_WIDTH:  p_width = v;
      REG_HEIGHT: p_height = v;
      default:    return;
    endcase
    restart_frame();
  endtask

  task automatic filter_step(logic md, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned w, h, rr, x0, x1, y0, y1, cnt, sr, sg, sb;
    mean_t       m;
    logic [23:0] p;
    w = dim_eff(p_width);
    h = dim_eff(p_height);
    rr = p_reach;
    if (!md && take_y < h && take_x < w) begin
      pix_ring[take_y % RING][take_x] = {r, g, b};
      if (take_x + 1 >= w) begin
        take_x = 0;
        take_y++;
      end else begin
        take_x++;
      end
    end
    if (give_x >= w || give_y >= h) return;
    if (min_of(give_y + rr, h - 1) * w + min_of(give_x + rr, w - 1) >= take_y * w + take_x)
      return;
    x0 = (give_x > rr) ? give_x - rr : 0;
    y0 = (give_y > rr) ? give_y - rr : 0;
    x1 = min_of(give_x + rr, w - 1);
    y1 = min_of(give_y + rr, h - 1);
    sr = 0;
    sg = 0;
    sb = 0;
    for (int unsigned yy = y0; yy <= y1; yy++) begin
      for (int unsigned xx = x0; xx <= x1; xx++) begin
        p = pix_ring[yy % RING][xx];
        sr += p[23:16];
        sg += p[15:8];
        sb += p[7:0];
      end
    end
    cnt = (x1 - x0 + 1) * (y1 - y0 + 1);
    m.red = sr / cnt;
    m.green = sg / cnt;
    m.blue = sb / cnt;
    m.col = give_x;
    m.row = give_y;
    m.fend = (give_x == w - 1 && give_y == h - 1);
    pending_means.push_back(m);
    if (m.fend) begin
      restart_frame();
    end else if (give_x + 1 >= w) begin
      give_x = 0;
      give_y++;
    end else begin
      give_x++;
    end
  endtask

  // Plan building
  int unsigned g_reach = 1, g_w = 640, g_h = 480, g_pix = 0;

  task automatic plan_word(logic md, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    cmd_t c;
    c.kind = CMD_WORD;
    c.mode = md;
    c.red = r;
    c.green = g;
    c.blue = b;
    word_plan.push_back(c);
    g_pix++;
  endtask

  task automatic plan_ctrl(cmd_e k, cfg_reg_e idx, int unsigned v, int unsigned sp,
                           int unsigned tp);
    cmd_t c;
    c.kind = k;
    c.idx = idx;
    c.data = v;
    c.send_pct = sp;
    c.stall_pct = tp;
    word_plan.push_back(c);
    if (k == CMD_CFG) begin
      case (idx)
        REG_REACH:  g_reach = v % 4;
        REG_WIDTH:  g_w = dim_eff(v);
        REG_HEIGHT: g_h = dim_eff(v);
        default: ;
      endcase
    end
  endtask

  task automatic plan_cfg(int unsigned r, int unsigned w, int unsigned h);
    plan_ctrl(CMD_SYNC, REG_NONE, 0, 0, 0);
    plan_ctrl(CMD_CFG, REG_REACH, r, 0, 0);
    plan_ctrl(CMD_CFG, REG_WIDTH, w, 0, 0);
    plan_ctrl(CMD_CFG, REG_HEIGHT, h, 0, 0);
  endtask

  // 0 < cut < frame size stops the frame after that many pixels and leaves it pending
  task automatic plan_frame(int unsigned cut, bit extremes);
    int unsigned n, lim;
    logic [7:0]  v;
    n = g_w * g_h;
    lim = (cut > 0 && cut < n) ? cut : n;
    for (int unsigned k = 0; k < lim; k++) begin
      if ($urandom_range(9) == 0)
        plan_word(1'b1, $urandom, $urandom, $urandom);
      if (extremes) begin
        v = (k % 2) ? 8'hFF : 8'h00;
        plan_word(1'b0, v, ~v, v);
      end else begin
        plan_word(1'b0, $urandom, $urandom, $urandom);
      end
    end
    if (lim < n) begin
      plan_ctrl(CMD_SYNC, REG_NONE, 0, 0, 0);
      return;
    end
    // a surplus pixel is dropped and drains like a flush
    if (g_reach >= 1 && n >= 2 && $urandom_range(1))
      plan_word(1'b0, $urandom, $urandom, $urandom);
    for (int unsigned k = 0; k < g_reach * (g_w + 1) + 1; k++)
      plan_word(1'b1, $urandom, $urandom, $urandom);
  endtask

  initial begin
    int unsigned ph;
    int unsigned phases [4][2];
    phases = '{'{0, 0}, '{56, 0}, '{0, 56}, '{32, 32}};
    // directed: single pixel, extremes at full reach, odd register values
    plan_cfg(0, 1, 1);
    plan_word(1'b0, 8'hFF, 8'h00, 8'hA5);
    plan_word(1'b1, 8'h00, 8'hFF, 8'h00);
    plan_cfg(3, 3, 2);
    plan_frame(0, 1'b1);
    plan_ctrl(CMD_SYNC, REG_NONE, 0, 0, 0);
    plan_ctrl(CMD_CFG, REG_NONE, 5, 0, 0);
    plan_cfg(1, 0, 0);
    plan_frame(0, 1'b1);
    plan_cfg(2, 2047, 0);
    plan_frame(40, 1'b0);
    plan_cfg(3, 1, 2047);
    plan_frame(30, 1'b0);
    plan_cfg(2, 1024, 1);
    plan_frame(20, 1'b1);
    ph = 0;
    while (g_pix < N_PIX) begin
      plan_ctrl(CMD_PHASE, REG_NONE, 0, phases[ph % 4][0], phases[ph % 4][1]);
      ph++;
      plan_cfg($urandom_range(3),
               ($urandom_range(4) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1),
               $urandom_range(8, 1));
      if (ph % 5 == 2) begin
        plan_ctrl(CMD_PHASE, REG_NONE, 0, 0, 0);
        plan_ctrl(CMD_HOLD, REG_NONE, 0, 0, 0);
      end
      repeat ($urandom_range(3, 1)) begin
        if ($urandom_range(9) == 0)
          plan_frame($urandom_range(g_w * g_h), 1'b0);
        else
          plan_frame(0, 1'b0);
      end
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (word_plan.size() == 0 && !in_valid && !cfg_valid && !waiting && quiet_cnt == 0
          && pending_means.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
    if (pending_means.size() != 0) begin
      $display("%0t: %0d means never arrived", $time, pending_means.size());
      fail_seen = 1'b1;
    end
    if (!fail_seen) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Sender: one word or register write at a time, hold while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    logic nv, ncv;
    cmd_t c;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
      p_reach = 1;
      p_width = 640;
      p_height = 480;
      restart_frame();
    end else begin
      nv = in_valid;
      ncv = cfg_valid;
      if (in_valid && !in_stall) begin
        filter_step(mode, red_in, green_in, blue_in);
        nv = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        apply_reg(cfg_reg_e'(cfg_index), cfg_data);
        ncv = 1'b0;
      end
      if (quiet_cnt > 0) begin
        quiet_cnt--;
      end else if (waiting) begin
        if (pending_means.size() == 0) begin
          waiting = 1'b0;
          quiet_cnt = SETTLE;
        end
      end else if (!nv && !ncv) begin
        while (word_plan.size() > 0 &&
               (word_plan[0].kind == CMD_PHASE || word_plan[0].kind == CMD_HOLD)) begin
          c = word_plan.pop_front();
          if (c.kind == CMD_PHASE) begin
            send_pct = c.send_pct;
            stall_pct <= c.stall_pct;
          end else begin
            hold_seq <= hold_seq + 1;
          end
        end
        if (word_plan.size() > 0) begin
          c = word_plan[0];
          case (c.kind)
            CMD_WORD: begin
              if ($urandom_range(99) >= send_pct) begin
                mode <= c.mode;
                red_in <= c.red;
                green_in <= c.green;
                blue_in <= c.blue;
                nv = 1'b1;
                void'(word_plan.pop_front());
              end
            end
            CMD_CFG: begin
              cfg_index <= c.idx;
              cfg_data <= c.data;
              ncv = 1'b1;
              void'(word_plan.pop_front());
            end
            default: begin
              void'(word_plan.pop_front());
              waiting = 1'b1;
            end
          endcase
        end
      end
      in_valid <= nv;
      cfg_valid <= ncv;
    end
  end

  // Receiver stall, with a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_cnt <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Result check against the oldest predicted mean
  always @(posedge clk_i) begin
    mean_t m;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_means.size() == 0) begin
        $display("%0t: unexpected word col %0d row %0d", $time, out_column, out_row);
        fail_seen = 1'b1;
      end else begin
        m = pending_means.pop_front();
        if (m.red !== red_mean || m.green !== green_mean || m.blue !== blue_mean ||
            m.col !== out_column || m.row !== out_row || m.fend !== frame_end) begin
          $display("%0t: mismatch exp rgb %0d/%0d/%0d at %0d,%0d end %0b", $time,
                   m.red, m.green, m.blue, m.col, m.row, m.fend);
          $display("%0t:          got rgb %0d/%0d/%0d at %0d,%0d end %0b", $time,
                   red_mean, green_mean, blue_mean, out_column, out_row, frame_end);
          fail_seen = 1'b1;
        end
      end
    end
  end

  // Watchdog: cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        dog_cnt <= 0;
      end else if (dog_cnt >= DOG_MAX) begin
        $display("%0t: no progress in %0d cycles", $time, DOG_MAX);
        $display("status: fail");
        $finish;
      end else begin
        dog_cnt <= dog_cnt + 1;
      end
    end
  end

endmodule
